### rtl/sobs_pkg.sv
// Shared constants, command and status codes, and types for the set of bounded stacks.
// Used by sobs_store.sv, set_of_bounded_stacks.sv and the bench; depends on nothing else.
package sobs_pkg;

   // Store geometry.
   localparam int STACK_COUNT       = 8;
   localparam int ENTRIES_PER_STACK = 8;
   localparam int STORE_DEPTH       = STACK_COUNT * ENTRIES_PER_STACK;
   localparam int ADDR_W            = $clog2(STORE_DEPTH);
   localparam int SIDX_W            = $clog2(STACK_COUNT);
   localparam int FILL_W            = $clog2(ENTRIES_PER_STACK + 1);

   // Field widths fixed by the interface.
   localparam int VALUE_W  = 32;
   localparam int CMD_W    = 2;
   localparam int STATUS_W = 2;
   localparam int INDEX_W  = 3;
   localparam int LIMIT_W  = 4;

   localparam logic [LIMIT_W-1:0] LIMIT_RESET = 4'd5;

   // Command codes.
   localparam logic [CMD_W-1:0] CMD_PUSH   = 2'd0;
   localparam logic [CMD_W-1:0] CMD_POP    = 2'd1;
   localparam logic [CMD_W-1:0] CMD_POP_AT = 2'd2;

   // Status codes.
   localparam logic [STATUS_W-1:0] ST_DONE   = 2'd0;
   localparam logic [STATUS_W-1:0] ST_EMPTY  = 2'd1;
   localparam logic [STATUS_W-1:0] ST_BEYOND = 2'd2;
   localparam logic [STATUS_W-1:0] ST_FULL   = 2'd3;

   // Register index of the stack limit.
   localparam logic REG_STACK_LIMIT = 1'b0;

   // One access to the entry memory.
   typedef struct packed {
      logic              wr_en;
      logic              rd_en;
      logic [ADDR_W-1:0] addr;
   } store_req_type;

endpackage

### rtl/sobs_store.sv
// Entry memory of the set of bounded stacks: one port, write or registered read.
// Depends on sobs_pkg for the depth, widths and the access struct.
module sobs_store (
   input  logic                                clock,
   input  sobs_pkg::store_req_type             req,
   input  logic [sobs_pkg::VALUE_W-1:0]        wdata,
   output logic [sobs_pkg::VALUE_W-1:0]        rdata
);

   logic [sobs_pkg::VALUE_W-1:0] mem [sobs_pkg::STORE_DEPTH];
   logic [sobs_pkg::VALUE_W-1:0] rdata_ff;

   // Synchronous write and registered read; entries carry no reset.
   always_ff @(posedge clock) begin
      if (req.wr_en) begin
         mem[req.addr] <= wdata;
      end
      if (req.rd_en) begin
         rdata_ff <= mem[req.addr];
      end
   end

   assign rdata = rdata_ff;

endmodule

### rtl/set_of_bounded_stacks.sv
// Set of bounded stacks top level: command sequencer, fill counts and ports; uses sobs_pkg.
// Each accepted word passes the check step and then the output step; a pop that reads the memory
// adds a read step, a push that fills a stack below the last adds a clear step, and a pop that
// steps back to the previous stack adds a back step (and a read step if that stack holds entries).
// One word at a time: a new word is taken only once the last response is loaded, after rsp stalls.
// Reset clears fill counts, the active stack index and the limit (to 5); no clearing pass.
module set_of_bounded_stacks (
   input  logic        clock,
   input  logic        reset,
   // Request stream.
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [39:0] req_tdata,  // [31:0] push_value, [34:32] stack_index, rest zero
   input  logic [1:0]  req_tuser,  // [1:0] command
   // Response stream.
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,  // [31:0] popped_value
   output logic [1:0]  rsp_tuser,  // [1:0] status
   // Register port.
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_CHECK = 3'd1;
   localparam logic [2:0] S_BACK  = 3'd2;
   localparam logic [2:0] S_CLEAR = 3'd3;
   localparam logic [2:0] S_READ  = 3'd4;
   localparam logic [2:0] S_OUT   = 3'd5;

   localparam int SW = sobs_pkg::SIDX_W;
   localparam int FW = sobs_pkg::FILL_W;
   localparam int AW = sobs_pkg::ADDR_W;
   localparam int VW = sobs_pkg::VALUE_W;

   logic [2:0]                      state_ff, state_in;
   logic [sobs_pkg::CMD_W-1:0]      cmd_ff, cmd_in;
   logic [VW-1:0]                   val_ff, val_in;
   logic [sobs_pkg::INDEX_W-1:0]    idx_ff, idx_in;
   logic [SW-1:0]                   stk_ff, stk_in;
   logic [SW-1:0]                   fca_ff, fca_in;
   logic [FW-1:0]                   fill_ff [sobs_pkg::STACK_COUNT];
   logic [VW-1:0]                   pend_val_ff, pend_val_in;
   logic [sobs_pkg::STATUS_W-1:0]   pend_st_ff, pend_st_in;
   logic                            rsp_valid_ff, rsp_valid_in;
   logic [VW-1:0]                   rsp_val_ff, rsp_val_in;
   logic [sobs_pkg::STATUS_W-1:0]   rsp_st_ff, rsp_st_in;
   logic [sobs_pkg::LIMIT_W-1:0]    limit_ff;

   logic                   req_take;
   logic                   csr_wr;
   logic                   fill_we;
   logic [FW-1:0]          fill_wdata;
   logic [FW-1:0]          cur_fill, fill_inc, fill_dec, eff_lim;
   logic [AW-1:0]          base_addr;
   sobs_pkg::store_req_type store_req;
   logic [VW-1:0]          store_rdata;

   // Register port: always ready, one register at byte address zero.
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel & csr_penable & csr_pwrite;
   assign csr_prdata = (csr_paddr[2] == sobs_pkg::REG_STACK_LIMIT)
                       ? {{(32-sobs_pkg::LIMIT_W){1'b0}}, limit_ff} : 32'd0;

   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff <= sobs_pkg::LIMIT_RESET;
      end else if (csr_wr && csr_paddr[2] == sobs_pkg::REG_STACK_LIMIT) begin
         limit_ff <= csr_pwdata[sobs_pkg::LIMIT_W-1:0];
      end
   end

   // Effective limit: zero acts as one, anything above the stack size is clipped.
   always_comb begin
      if (limit_ff == '0) begin
         eff_lim = FW'(1);
      end else if (32'(limit_ff) > sobs_pkg::ENTRIES_PER_STACK) begin
         eff_lim = FW'(sobs_pkg::ENTRIES_PER_STACK);
      end else begin
         eff_lim = FW'(limit_ff);
      end
   end

   // Fill count of the stack being worked on, and the entry addresses around its top.
   assign cur_fill  = fill_ff[stk_ff];
   assign fill_inc  = cur_fill + FW'(1);
   assign fill_dec  = cur_fill - FW'(1);
   assign base_addr = AW'(stk_ff) * AW'(sobs_pkg::ENTRIES_PER_STACK);

   assign req_tready = (state_ff == S_IDLE);
   assign req_take   = req_tvalid & req_tready;

   // Sequencer: check the fill count, then read or write the top entry, step back or clear a stack.
   always_comb begin
      state_in     = state_ff;
      cmd_in       = cmd_ff;
      val_in       = val_ff;
      idx_in       = idx_ff;
      stk_in       = stk_ff;
      fca_in       = fca_ff;
      pend_val_in  = pend_val_ff;
      pend_st_in   = pend_st_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_tready;
      rsp_val_in   = rsp_val_ff;
      rsp_st_in    = rsp_st_ff;
      fill_we      = 1'b0;
      fill_wdata   = fill_dec;
      store_req.wr_en = 1'b0;
      store_req.rd_en = 1'b0;
      store_req.addr  = base_addr + AW'(fill_dec);

      unique case (state_ff)
         S_IDLE: begin
            if (req_take) begin
               cmd_in   = req_tuser;
               val_in   = req_tdata[VW-1:0];
               idx_in   = req_tdata[VW+sobs_pkg::INDEX_W-1:VW];
               stk_in   = (req_tuser == sobs_pkg::CMD_POP_AT)
                          ? SW'(req_tdata[VW+sobs_pkg::INDEX_W-1:VW]) : fca_ff;
               state_in = S_CHECK;
            end
         end
         S_CHECK: begin
            pend_val_in = '0;
            pend_st_in  = sobs_pkg::ST_DONE;
            state_in    = S_OUT;
            case (cmd_ff) inside
               sobs_pkg::CMD_PUSH: begin
                  if (cur_fill >= eff_lim) begin
                     pend_st_in = sobs_pkg::ST_FULL;
                  end else begin
                     store_req.wr_en = 1'b1;
                     store_req.addr  = base_addr + AW'(cur_fill);
                     fill_we         = 1'b1;
                     fill_wdata      = fill_inc;
                     // A stack below the last just filled: the next one becomes active and starts empty.
                     if (fill_inc >= eff_lim && 32'(fca_ff) != sobs_pkg::STACK_COUNT - 1) begin
                        fca_in   = fca_ff + SW'(1);
                        stk_in   = fca_ff + SW'(1);
                        state_in = S_CLEAR;
                     end
                  end
               end
               sobs_pkg::CMD_POP, sobs_pkg::CMD_POP_AT: begin
                  if (cmd_ff == sobs_pkg::CMD_POP_AT && 32'(idx_ff) > 32'(fca_ff)) begin
                     pend_st_in = sobs_pkg::ST_BEYOND;
                  end else if (cur_fill != '0) begin
                     store_req.rd_en = 1'b1;
                     fill_we         = 1'b1;
                     state_in        = S_READ;
                     // Emptying the active stack hands activity back to the previous one, unless it is stack zero.
                     if (stk_ff == fca_ff && fill_dec == '0 && fca_ff != '0) begin
                        fca_in = fca_ff - SW'(1);
                     end
                  end else if (cmd_ff == sobs_pkg::CMD_POP && fca_ff != '0) begin
                     fca_in   = fca_ff - SW'(1);
                     stk_in   = fca_ff - SW'(1);
                     state_in = S_BACK;
                  end else begin
                     pend_st_in = sobs_pkg::ST_EMPTY;
                  end
               end
               default: begin
                  pend_st_in = sobs_pkg::ST_DONE;
               end
            endcase
         end
         S_BACK: begin
            // Pop from the previous stack, which pop-at may have emptied.
            if (cur_fill != '0) begin
               store_req.rd_en = 1'b1;
               fill_we         = 1'b1;
               state_in        = S_READ;
            end else begin
               pend_st_in = sobs_pkg::ST_EMPTY;
               state_in   = S_OUT;
            end
         end
         S_CLEAR: begin
            fill_we    = 1'b1;
            fill_wdata = '0;
            state_in   = S_OUT;
         end
         S_READ: begin
            pend_val_in = store_rdata;
            state_in    = S_OUT;
         end
         S_OUT: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_val_in   = pend_val_ff;
               rsp_st_in    = pend_st_ff;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Control registers and fill counts.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         fca_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < sobs_pkg::STACK_COUNT; i++) begin
            fill_ff[i] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         fca_ff       <= fca_in;
         rsp_valid_ff <= rsp_valid_in;
         if (fill_we) begin
            fill_ff[stk_ff] <= fill_wdata;
         end
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      cmd_ff      <= cmd_in;
      val_ff      <= val_in;
      idx_ff      <= idx_in;
      stk_ff      <= stk_in;
      pend_val_ff <= pend_val_in;
      pend_st_ff  <= pend_st_in;
      rsp_val_ff  <= rsp_val_in;
      rsp_st_ff   <= rsp_st_in;
   end

   sobs_store u_store (
      .clock (clock),
      .req   (store_req),
      .wdata (val_ff),
      .rdata (store_rdata)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_val_ff;
   assign rsp_tuser  = rsp_st_ff;

`ifndef SYNTHESIS
   // An accepted word always moves the sequencer into the check step.
   assert property (@(posedge clock) disable iff (reset)
      req_take |=> state_ff == S_CHECK)
      else $error("accepted word did not start the check step");

   // A memory read only follows a successful pop decision.
   assert property (@(posedge clock) disable iff (reset)
      state_ff == S_READ |-> pend_st_ff == sobs_pkg::ST_DONE)
      else $error("read step with a failing status");

   // The active stack never holds more entries than it has room for.
   assert property (@(posedge clock) disable iff (reset)
      32'(fill_ff[fca_ff]) <= sobs_pkg::ENTRIES_PER_STACK)
      else $error("active stack fill exceeds its size");

   // A pending response stays valid while the receiver stalls.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_tready |=> rsp_valid_ff)
      else $error("pending response dropped");
`endif

endmodule

### dv/set_of_bounded_stacks_test.sv
// Self-checking bench for set_of_bounded_stacks: streams command words, predicts each response.
// Depends on rtl/sobs_pkg.sv for codes and widths and on rtl/set_of_bounded_stacks.sv.
module set_of_bounded_stacks_test;

   localparam logic [sobs_pkg::CMD_W-1:0] CMD_UNUSED = 2'd3;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int DRAIN_CYCLES   = 8;
   localparam int SEGMENT_WORDS  = 258;
   localparam int BURST_WORDS    = 40;
   localparam int REPORT_MAX     = 10;
   localparam int SCRIPT_ROWS    = 25;

   typedef enum logic {ROW_WORD, ROW_LIMIT} row_kind_type;

   // One row of the directed script; a limit row carries the new limit in value.
   typedef struct {
      row_kind_type                    kind;
      logic [sobs_pkg::CMD_W-1:0]      cmd;
      logic [sobs_pkg::VALUE_W-1:0]    value;
      logic [sobs_pkg::INDEX_W-1:0]    index;
      bit                              typed;
      logic [sobs_pkg::VALUE_W-1:0]    exp_value;
      logic [sobs_pkg::STATUS_W-1:0]   exp_status;
   } script_row_type;

   typedef struct {
      logic [sobs_pkg::VALUE_W-1:0]  value;
      logic [sobs_pkg::STATUS_W-1:0] status;
   } response_type;

   logic        clock       = 1'b0;
   logic        reset       = 1'b1;
   logic        req_tvalid  = 1'b0;
   logic        req_tready;
   logic [39:0] req_tdata   = '0;  // [31:0] push_value, [34:32] stack_index, rest zero
   logic [1:0]  req_tuser   = '0;  // [1:0] command
   logic        rsp_tvalid;
   logic        rsp_tready  = 1'b0;
   logic [31:0] rsp_tdata;         // [31:0] popped_value
   logic [1:0]  rsp_tuser;         // [1:0] status
   logic        csr_psel    = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite  = 1'b0;
   logic [2:0]  csr_paddr   = '0;
   logic [31:0] csr_pwdata  = '0;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   response_type awaited_results [$];
   int        error_count    = 0;
   int        quiet_cycles   = 0;
   int        send_gap_pct   = 18;
   int        recv_stall_pct = 84;

   // Predictor state: entry memory, per-stack fill, active stack and limit register.
   logic [sobs_pkg::VALUE_W-1:0] model_entries [sobs_pkg::STORE_DEPTH];
   logic [sobs_pkg::FILL_W-1:0]  model_fill    [sobs_pkg::STACK_COUNT];
   logic [sobs_pkg::SIDX_W-1:0]  model_active  = '0;
   logic [sobs_pkg::LIMIT_W-1:0] model_limit   = sobs_pkg::LIMIT_RESET;

   set_of_bounded_stacks dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always #6 clock = ~clock;

   // Zero acts as one, and anything above the stack depth is clipped to it.
   function automatic int effective_limit();
      if (model_limit == 0) return 1;
      if (model_limit > sobs_pkg::ENTRIES_PER_STACK) return sobs_pkg::ENTRIES_PER_STACK;
      return int'(model_limit);
   endfunction

   function automatic logic [sobs_pkg::VALUE_W-1:0] take_top(int s);
      model_fill[s] = model_fill[s] - 1'b1;
      return model_entries[s * sobs_pkg::ENTRIES_PER_STACK + int'(model_fill[s])];
   endfunction

   // Pop from the active stack, stepping back to the previous stack when it runs dry.
   function automatic logic [sobs_pkg::STATUS_W-1:0] pop_active(
         output logic [sobs_pkg::VALUE_W-1:0] v);
      int a;
      a = int'(model_active);
      v = '0;
      if (model_fill[a] != 0) begin
         v = take_top(a);
         if (model_fill[a] == 0 && a != 0) model_active = model_active - 1'b1;
         return sobs_pkg::ST_DONE;
      end
      if (a == 0) return sobs_pkg::ST_EMPTY;
      model_active = model_active - 1'b1;
      if (model_fill[a - 1] == 0) return sobs_pkg::ST_EMPTY;
      v = take_top(a - 1);
      return sobs_pkg::ST_DONE;
   endfunction

   function automatic response_type predict_response(
         logic [sobs_pkg::CMD_W-1:0] cmd,
         logic [sobs_pkg::VALUE_W-1:0] value,
         logic [sobs_pkg::INDEX_W-1:0] index);
      response_type r;
      logic [sobs_pkg::VALUE_W-1:0] v;
      int a;
      int lim;
      v = '0;
      r.status = sobs_pkg::ST_DONE;
      a = int'(model_active);
      lim = effective_limit();
      case (cmd)
         sobs_pkg::CMD_PUSH: begin
            if (int'(model_fill[a]) >= lim) begin
               r.status = sobs_pkg::ST_FULL;
            end else begin
               model_entries[a * sobs_pkg::ENTRIES_PER_STACK + int'(model_fill[a])] = value;
               model_fill[a] = model_fill[a] + 1'b1;
               // The last stack stays active once it reaches the limit.
               if (int'(model_fill[a]) >= lim && a + 1 < sobs_pkg::STACK_COUNT) begin
                  model_active = model_active + 1'b1;
                  model_fill[a + 1] = '0;
               end
            end
         end
         sobs_pkg::CMD_POP: r.status = pop_active(v);
         sobs_pkg::CMD_POP_AT: begin
            if (int'(index) < a) begin
               if (model_fill[index] != 0) v = take_top(int'(index));
               else r.status = sobs_pkg::ST_EMPTY;
            end else if (int'(index) == a) begin
               if (model_fill[a] != 0) r.status = pop_active(v);
               else r.status = sobs_pkg::ST_EMPTY;
            end else begin
               r.status = sobs_pkg::ST_BEYOND;
            end
         end
         default: ;
      endcase
      r.value = (r.status == sobs_pkg::ST_DONE) ? v : '0;
      return r;
   endfunction

   task automatic note_failure(string what);
      error_count++;
      if (error_count <= REPORT_MAX) $display("%0t: %s", $time, what);
   endtask

   // Offer one word with random gaps and record its expected response once accepted.
   task automatic send_word(logic [sobs_pkg::CMD_W-1:0] cmd,
                            logic [sobs_pkg::VALUE_W-1:0] value,
                            logic [sobs_pkg::INDEX_W-1:0] index, bit typed = 1'b0,
                            logic [sobs_pkg::VALUE_W-1:0] exp_value = '0,
                            logic [sobs_pkg::STATUS_W-1:0] exp_status = sobs_pkg::ST_DONE);
      response_type predicted;
      @(negedge clock);
      while ($urandom_range(99) < send_gap_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= cmd;
      req_tdata  <= {5'b0, index, value};
      do @(posedge clock); while (!req_tready);
      predicted = predict_response(cmd, value, index);
      if (typed) begin
         predicted.value  = exp_value;
         predicted.status = exp_status;
      end
      awaited_results.insert(awaited_results.size(), predicted);
   endtask

   // Stop offering words, let every response come back, then let the block settle.
   task automatic wait_idle();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (awaited_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_limit(logic [sobs_pkg::LIMIT_W-1:0] limit);
      @(negedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {sobs_pkg::REG_STACK_LIMIT, 2'b00};
      csr_pwdata  <= 32'(limit);
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      model_limit = limit;
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
   endtask

   // The receiver stalls at random.
   always @(negedge clock) rsp_tready <= ($urandom_range(99) >= recv_stall_pct);

   // Compare every accepted response with the oldest expectation, and watch for a hang.
   always @(posedge clock) begin : response_check
      response_type want;
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            if (awaited_results.size() == 0) begin
               note_failure($sformatf("unexpected response value %h status %0d",
                                      rsp_tdata, rsp_tuser));
            end else begin
               want = awaited_results.pop_front();
               if (rsp_tdata !== want.value || rsp_tuser !== want.status)
                  note_failure($sformatf(
                     "mismatch: expected value %h status %0d, got value %h status %0d",
                     want.value, want.status, rsp_tdata, rsp_tuser));
            end
         end
         if ((rsp_tvalid && rsp_tready) || (req_tvalid && req_tready)) quiet_cycles = 0;
         else quiet_cycles++;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("set_of_bounded_stacks_test: done, errors");
            $finish;
         end
      end
   end

   initial begin
      script_row_type script [SCRIPT_ROWS];
      logic [sobs_pkg::LIMIT_W-1:0] seg_limit [6];
      logic [sobs_pkg::CMD_W-1:0]   cmd;
      logic [sobs_pkg::VALUE_W-1:0] value;
      logic [sobs_pkg::INDEX_W-1:0] index;
      int push_pct;

      // Empty store, unused code, sign extremes, limit zero filling every stack,
      // a full store, and a pop that steps back onto a stack emptied by pop-at.
      script = '{
         '{ROW_WORD, sobs_pkg::CMD_POP, 32'h0, 3'd0, 1'b1, 32'h0, sobs_pkg::ST_EMPTY},
         '{ROW_WORD, sobs_pkg::CMD_POP_AT, 32'h0, 3'd0, 1'b1, 32'h0, sobs_pkg::ST_EMPTY},
         '{ROW_WORD, sobs_pkg::CMD_POP_AT, 32'h0, 3'd7, 1'b1, 32'h0, sobs_pkg::ST_BEYOND},
         '{ROW_WORD, CMD_UNUSED, 32'hFFFF_FFFF, 3'd7, 1'b1, 32'h0, sobs_pkg::ST_DONE},
         '{ROW_WORD, sobs_pkg::CMD_PUSH, 32'h8000_0000, 3'd0, 1'b1, 32'h0, sobs_pkg::ST_DONE},
         '{ROW_WORD, sobs_pkg::CMD_POP, 32'h0, 3'd0, 1'b1, 32'h8000_0000, sobs_pkg::ST_DONE},
         '{ROW_LIMIT, sobs_pkg::CMD_PUSH, 32'h0, 3'd0, 1'b0, 32'h0, sobs_pkg::ST_DONE},
         '{ROW_WORD, sobs_pkg::CMD_PUSH, 32'h7FFF_FFFF, 3'd0, 1'b1, 32'h0, sobs_pkg::ST_DONE},
         '{ROW_WORD, sobs_pkg::CMD_PUSH, 32'hFFFF_FFFF, 3'd0, 1'b1, 32'h0, sobs_pkg::ST_DONE},
         '{ROW_WORD, sobs_pkg::CMD_POP_AT, 32'h0, 3'd1, 1'b1, 32'hFFFF_FFFF, sobs_pkg::ST_DONE},
         '{ROW_WORD, sobs_pkg::CMD_POP, 32'h0, 3'd0, 1'b1, 32'h0, sobs_pkg::ST_EMPTY},
         '{ROW_WORD, sobs_pkg::CMD_POP, 32'h0, 3'd0, 1'b1, 32'h7FFF_FFFF, sobs_pkg::ST_DONE},
         '{ROW_WORD, sobs_pkg::CMD_PUSH, 32'h0, 3'd0, 1'b0, 32'h0, sobs_pkg::ST_DONE},
         '{ROW_WORD, sobs_pkg::CMD_PUSH, 32'h0000_0001, 3'd0, 1'b0, 32'h0, sobs_pkg::ST_DONE},
         '{ROW_WORD, sobs_pkg::CMD_PUSH, 32'h5555_5555, 3'd0, 1'b0, 32'h0, sobs_pkg::ST_DONE},
         '{ROW_WORD, sobs_pkg::CMD_PUSH, 32'hAAAA_AAAA, 3'd0, 1'b0, 32'h0, sobs_pkg::ST_DONE},
         '{ROW_WORD, sobs_pkg::CMD_PUSH, 32'h1234_5678, 3'd0, 1'b0, 32'h0, sobs_pkg::ST_DONE},
         '{ROW_WORD, sobs_pkg::CMD_PUSH, 32'hFFFF_FFFE, 3'd0, 1'b0, 32'h0, sobs_pkg::ST_DONE},
         '{ROW_WORD, sobs_pkg::CMD_PUSH, 32'h8000_0001, 3'd0, 1'b0, 32'h0, sobs_pkg::ST_DONE},
         '{ROW_WORD, sobs_pkg::CMD_PUSH, 32'h7FFF_FFFE, 3'd0, 1'b0, 32'h0, sobs_pkg::ST_DONE},
         '{ROW_WORD, sobs_pkg::CMD_PUSH, 32'h5A5A_5A5A, 3'd0, 1'b1, 32'h0, sobs_pkg::ST_FULL},
         '{ROW_WORD, sobs_pkg::CMD_POP_AT, 32'h0, 3'd7, 1'b0, 32'h0, sobs_pkg::ST_DONE},
         '{ROW_WORD, sobs_pkg::CMD_POP_AT, 32'h0, 3'd4, 1'b0, 32'h0, sobs_pkg::ST_DONE},
         '{ROW_WORD, sobs_pkg::CMD_POP, 32'h0, 3'd0, 1'b0, 32'h0, sobs_pkg::ST_DONE},
         '{ROW_LIMIT, sobs_pkg::CMD_PUSH, 32'h0000_000F, 3'd0, 1'b0, 32'h0, sobs_pkg::ST_DONE}
      };
      seg_limit = '{4'd8, 4'd15, 4'd1, 4'd3, 4'd0, 4'($urandom_range(2, 7))};

      foreach (model_entries[i]) model_entries[i] = '0;
      foreach (model_fill[i]) model_fill[i] = '0;

      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed script.
      foreach (script[i]) begin
         if (script[i].kind == ROW_LIMIT) begin
            wait_idle();
            write_limit(script[i].value[sobs_pkg::LIMIT_W-1:0]);
         end else begin
            send_word(script[i].cmd, script[i].value, script[i].index, script[i].typed,
                      script[i].exp_value, script[i].exp_status);
         end
      end

      // Random segments, each under its own limit; pairs of segments share an idling mode.
      for (int seg = 0; seg < 6; seg++) begin
         wait_idle();
         write_limit(seg_limit[seg]);
         send_gap_pct   = (seg < 2) ? 18 : (seg < 4) ? 84 : 0;
         recv_stall_pct = (seg < 2) ? 84 : (seg < 4) ? 18 : 0;
         push_pct = 50;
         for (int n = 0; n < SEGMENT_WORDS; n++) begin
            // Bursts lean toward pushes or pops so the store both fills and drains.
            if (n % BURST_WORDS == 0) push_pct = $urandom_range(15, 85);
            if ($urandom_range(99) < 3) cmd = CMD_UNUSED;
            else if ($urandom_range(99) < push_pct) cmd = sobs_pkg::CMD_PUSH;
            else if ($urandom_range(1) == 0) cmd = sobs_pkg::CMD_POP;
            else cmd = sobs_pkg::CMD_POP_AT;
            case ($urandom_range(7))
               0: value = 32'h8000_0000;
               1: value = 32'h7FFF_FFFF;
               2: value = '0;
               3: value = '1;
               default: value = $urandom();
            endcase
            // Pop-at mostly picks a stack at or below the active one.
            if (cmd == sobs_pkg::CMD_POP_AT && $urandom_range(99) < 75)
               index = sobs_pkg::INDEX_W'($urandom_range(0, int'(model_active)));
            else
               index = sobs_pkg::INDEX_W'($urandom_range(0, sobs_pkg::STACK_COUNT - 1));
            send_word(cmd, value, index);
         end
      end

      wait_idle();
      if (error_count == 0) begin
         $display("set_of_bounded_stacks_test: done, clean");
      end else begin
         $display("set_of_bounded_stacks_test: done, errors");
      end
      $finish;
   end

endmodule

### files.f
rtl/sobs_pkg.sv
rtl/sobs_store.sv
rtl/set_of_bounded_stacks.sv
dv/set_of_bounded_stacks_test.sv
